### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int OP_WIDTH = 2;

	localparam logic [OP_WIDTH-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_POP   = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_QUERY = 2'd2;

	// Occupancy of the result buffer at the output.
	typedef enum logic [1:0] {
		ST_EMPTY,
		ST_ONE,
		ST_TWO
	} spq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic apply;      // update the queue with the accepted item
		logic load_head;  // new result goes to the output register
		logic load_skid;  // new result goes to the skid register
		logic pop_skid;   // skid register moves to the output register
	} spq_cmd_t;

endpackage

`default_nettype wire

### hdl/spq_ctrl.sv
// Controller of the priority queue: handshakes and result buffer sequencing.
`default_nettype none

module spq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output spq_pkg::spq_cmd_t      cmd
);

	spq_pkg::spq_state_t state_q;
	spq_pkg::spq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::ST_EMPTY: begin
				if (s_tvalid) begin
					state_d = spq_pkg::ST_ONE;
				end
			end
			spq_pkg::ST_ONE: begin
				if (s_tvalid && !m_tready) begin
					state_d = spq_pkg::ST_TWO;
				end else if (!s_tvalid && m_tready) begin
					state_d = spq_pkg::ST_EMPTY;
				end
			end
			spq_pkg::ST_TWO: begin
				if (m_tready) begin
					state_d = spq_pkg::ST_ONE;
				end
			end
			default: begin
				state_d = spq_pkg::ST_EMPTY;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			spq_pkg::ST_EMPTY: begin
				s_tready      = 1'b1;
				cmd.apply     = s_tvalid;
				cmd.load_head = s_tvalid;
			end
			spq_pkg::ST_ONE: begin
				s_tready      = 1'b1;
				m_tvalid      = 1'b1;
				cmd.apply     = s_tvalid;
				cmd.load_head = s_tvalid && m_tready;
				cmd.load_skid = s_tvalid && !m_tready;
			end
			spq_pkg::ST_TWO: begin
				m_tvalid     = 1'b1;
				cmd.pop_skid = m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/spq_datapath.sv
// Datapath of the priority queue: sorted slot array and result registers.
`default_nettype none

module spq_datapath #(
	parameter int CAPACITY       = 16,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16,
	parameter int CW             = $clog2(CAPACITY + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spq_pkg::spq_cmd_t             cmd,
	input  wire logic [spq_pkg::OP_WIDTH-1:0]  opcode,
	input  wire logic [DATA_WIDTH-1:0]         item_data,
	input  wire logic [PRIORITY_WIDTH-1:0]     item_priority,
	output logic [DATA_WIDTH-1:0]              head_data,
	output logic                               head_valid,
	output logic [CW-1:0]                      occupancy,
	output logic                               push_dropped
);

	logic [DATA_WIDTH-1:0]     data_q [CAPACITY];
	logic [PRIORITY_WIDTH-1:0] prio_q [CAPACITY];
	logic [CW-1:0]             count_q;

	// less[i]: slot i holds an entry that stays ahead of the new one.
	logic [CAPACITY-1:0] less;
	logic                push_ok;
	logic                pop_ok;
	logic                is_push;

	assign is_push = (opcode == spq_pkg::OP_PUSH);
	assign push_ok = is_push && (count_q != CW'(CAPACITY));
	assign pop_ok  = (opcode == spq_pkg::OP_POP) && (count_q != '0);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		logic                      take_new;
		logic [DATA_WIDTH-1:0]     up_data;
		logic [PRIORITY_WIDTH-1:0] up_prio;
		logic [DATA_WIDTH-1:0]     down_data;
		logic [PRIORITY_WIDTH-1:0] down_prio;

		assign less[i] = (CW'(i) < count_q) &&
			($signed(prio_q[i]) < $signed(item_priority));

		if (i == 0) begin : g_first
			assign take_new = 1'b1;
			assign up_data  = item_data;
			assign up_prio  = item_priority;
		end else begin : g_rest
			assign take_new = less[i-1];
			assign up_data  = data_q[i-1];
			assign up_prio  = prio_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign down_data = data_q[i];
			assign down_prio = prio_q[i];
		end else begin : g_inner
			assign down_data = data_q[i+1];
			assign down_prio = prio_q[i+1];
		end

		// Insert: slots ahead of the new entry hold, the first one behind takes
		// it, the rest move one place toward the tail. Pop moves all toward the head.
		always_ff @(posedge clk) begin
			if (cmd.apply && push_ok && !less[i]) begin
				if (take_new) begin
					data_q[i] <= item_data;
					prio_q[i] <= item_priority;
				end else begin
					data_q[i] <= up_data;
					prio_q[i] <= up_prio;
				end
			end else if (cmd.apply && pop_ok) begin
				data_q[i] <= down_data;
				prio_q[i] <= down_prio;
			end
		end
	end

	// Result of the accepted item, taken from the queue after its operation.
	logic [CW-1:0]         res_count;
	logic [DATA_WIDTH-1:0] res_head;
	logic [DATA_WIDTH-1:0] res_data;

	always_comb begin
		res_count = count_q;
		res_head  = data_q[0];
		if (push_ok) begin
			res_count = count_q + CW'(1);
			res_head  = less[0] ? data_q[0] : item_data;
		end else if (pop_ok) begin
			res_count = count_q - CW'(1);
			res_head  = data_q[1];
		end
		res_data = (res_count != '0) ? res_head : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			count_q <= res_count;
		end
	end

	logic [DATA_WIDTH-1:0] skid_data_q;
	logic                  skid_valid_q;
	logic [CW-1:0]         skid_count_q;
	logic                  skid_drop_q;
	logic                  res_drop;

	assign res_drop = is_push && !push_ok;

	always_ff @(posedge clk) begin
		if (cmd.load_skid) begin
			skid_data_q  <= res_data;
			skid_valid_q <= (res_count != '0);
			skid_count_q <= res_count;
			skid_drop_q  <= res_drop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_head) begin
			head_data    <= res_data;
			head_valid   <= (res_count != '0);
			occupancy    <= res_count;
			push_dropped <= res_drop;
		end else if (cmd.pop_skid) begin
			head_data    <= skid_data_q;
			head_valid   <= skid_valid_q;
			occupancy    <= skid_count_q;
			push_dropped <= skid_drop_q;
		end
	end

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller, datapath and port packing.
//
// The block keeps up to CAPACITY entries sorted by signed priority, lowest
// first; among equal priorities the most recently pushed entry is served first.
// Items arrive on the s_ channel: s_tuser carries the opcode (push, pop or
// query; the unused code acts as a query), s_tdata the data and priority of a
// pushed entry. Every accepted item produces exactly one result item on the m_
// channel with the head entry's data (zero when empty), a head-valid flag in
// m_tuser, the occupancy and a flag set when a push was refused on a full queue.
// A pop of an empty queue changes nothing.
// The result of an item is registered, in the skid register if the output stalls.
// The insert compares the new priority against all slots in parallel and
// shifts the sorted slot array, so one item is taken every cycle while s_tready is high.
// A two-entry result buffer (output register plus skid register) sits at the
// output: when the receiver stalls, one more item is accepted and its result
// parked, after which s_tready drops until the receiver takes a result.
// Reset empties the queue and the result buffer; stored slots are not cleared,
// since only slots below the occupancy are ever read.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue #(
	parameter int CAPACITY       = 16,
	parameter int DATA_WIDTH     = 32,
	parameter int PRIORITY_WIDTH = 16,
	localparam int CW            = $clog2(CAPACITY + 1),
	localparam int IN_TDATA_W    = ((DATA_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W   = ((DATA_WIDTH + CW + 1 + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// item_data, item_priority (from bit 0 up), zero padded
	input  wire logic [IN_TDATA_W-1:0]         s_tdata,
	// opcode
	input  wire logic [spq_pkg::OP_WIDTH-1:0]  s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// head_data, occupancy, push_dropped (from bit 0 up), zero padded
	output logic [OUT_TDATA_W-1:0]             m_tdata,
	// head_valid
	output logic                               m_tuser
);

	spq_pkg::spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	logic [DATA_WIDTH-1:0] head_data;
	logic                  head_valid;
	logic [CW-1:0]         occupancy;
	logic                  push_dropped;

	spq_datapath #(
		.CAPACITY       (CAPACITY),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.CW             (CW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (s_tuser),
		.item_data     (s_tdata[DATA_WIDTH-1:0]),
		.item_priority (s_tdata[DATA_WIDTH+PRIORITY_WIDTH-1:DATA_WIDTH]),
		.head_data     (head_data),
		.head_valid    (head_valid),
		.occupancy     (occupancy),
		.push_dropped  (push_dropped)
	);

	assign m_tdata = OUT_TDATA_W'({push_dropped, occupancy, head_data});
	assign m_tuser = head_valid;

	// The queue never reports more entries than it can hold.
	`SPQ_ASSERT_SAME(a_occ_bound, m_tvalid, occupancy <= CW'(CAPACITY), "occupancy above capacity")
	// Head valid agrees with the occupancy.
	`SPQ_ASSERT_SAME(a_head_valid, m_tvalid, head_valid == (occupancy != '0), "head valid mismatch")
	// A refused push only happens on a full queue.
	`SPQ_ASSERT_SAME(a_drop_full, m_tvalid && push_dropped, occupancy == CW'(CAPACITY), "drop not full")
	// With no result pending the block always takes an item.
	`SPQ_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "idle but not ready")
	// An accepted item always leaves a result pending in the next cycle.
	`SPQ_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "result missing")

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the sorted priority queue with random handshake stalls.
`timescale 1ns / 100ps

module tb;

	localparam int CAPACITY    = 16;
	localparam int DW          = 32;
	localparam int PW          = 16;
	localparam int CW          = 5;
	localparam int IN_W        = ((DW + PW + 7) / 8) * 8;
	localparam int OUT_W       = ((DW + CW + 1 + 7) / 8) * 8;
	localparam int RANDOM_OPS  = 1125;
	localparam int QUIET_LIMIT = 2000;

	// The spare opcode value behaves like a query.
	localparam logic [spq_pkg::OP_WIDTH-1:0] OP_SPARE = 2'd3;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_TIE} load_mode_t;

	typedef struct packed {
		logic [spq_pkg::OP_WIDTH-1:0] opcode;
		logic [DW-1:0]                data;
		logic [PW-1:0]                prio;
	} queue_op_t;

	typedef struct packed {
		logic [DW-1:0] head_data;
		logic          head_valid;
		logic [CW-1:0] occupancy;
		logic          push_dropped;
	} queue_report_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [IN_W-1:0]              s_tdata  = '0;
	logic [spq_pkg::OP_WIDTH-1:0] s_tuser  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [OUT_W-1:0]             m_tdata;
	logic                         m_tuser;

	sorted_priority_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Shadow copy of the sorted slots, head at index 0.
	logic [DW-1:0]        slot_data [CAPACITY];
	logic signed [PW-1:0] slot_prio [CAPACITY];
	int                   held = 0;

	queue_op_t     pending_ops[$];
	queue_report_t expected_reports[$];
	queue_op_t     cur_op;

	int total_ops    = 0;
	int accepted_ops = 0;
	int checked      = 0;
	int failures     = 0;
	int n_pushes     = 0;
	int n_pops       = 0;
	int n_refused    = 0;
	int n_empty_pops = 0;
	int n_full       = 0;

	int in_gap     = 0;
	int in_calm    = 0;
	int out_stall  = 0;
	int out_calm   = 0;
	int quiet      = 0;

	logic [DW-1:0] got_data;
	logic [CW-1:0] got_occ;
	logic          got_dropped;
	queue_report_t want;

	function automatic queue_report_t step_queue(queue_op_t op);
		queue_report_t rep;
		int pos;
		int j;
		rep = '0;
		case (op.opcode)
			spq_pkg::OP_PUSH: begin
				n_pushes++;
				if (held == CAPACITY) begin
					rep.push_dropped = 1'b1;
					n_refused++;
				end else begin
					// New entry goes ahead of the first equal or greater priority.
					pos = 0;
					while (pos < held && slot_prio[pos] < $signed(op.prio))
						pos++;
					for (j = held; j > pos; j--) begin
						slot_data[j] = slot_data[j-1];
						slot_prio[j] = slot_prio[j-1];
					end
					slot_data[pos] = op.data;
					slot_prio[pos] = $signed(op.prio);
					held++;
					if (held == CAPACITY)
						n_full++;
				end
			end
			spq_pkg::OP_POP: begin
				n_pops++;
				if (held == 0) begin
					n_empty_pops++;
				end else begin
					for (j = 0; j + 1 < held; j++) begin
						slot_data[j] = slot_data[j+1];
						slot_prio[j] = slot_prio[j+1];
					end
					held--;
				end
			end
			default: ;
		endcase
		rep.head_data  = (held > 0) ? slot_data[0] : '0;
		rep.head_valid = (held > 0);
		rep.occupancy  = CW'(held);
		return rep;
	endfunction

	// Mostly short gaps, some long ones, and runs of back-to-back traffic.
	function automatic int gap_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PW-1:0] pick_prio(load_mode_t mode);
		int r;
		if (mode == MODE_TIE)
			return PW'($urandom_range(0, 2) - 1);
		r = $urandom_range(0, 99);
		if (r < 40)
			return PW'($urandom_range(0, 65535));
		else if (r < 75)
			return PW'($urandom_range(0, 6) - 3);
		else if (r < 85)
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h8001;
				default: return 16'h7ffe;
			endcase
		return PW'($urandom_range(0, 200) - 100);
	endfunction

	function automatic logic [DW-1:0] pick_data();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			default: return 32'h7fff_ffff;
		endcase
	endfunction

	task automatic add_op(logic [spq_pkg::OP_WIDTH-1:0] opcode, logic [DW-1:0] data,
			logic [PW-1:0] prio);
		queue_op_t op;
		op.opcode = opcode;
		op.data   = data;
		op.prio   = prio;
		pending_ops.push_back(op);
		total_ops++;
	endtask

	// Item source: loads the next pending item once the bus is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_reports.push_back(step_queue(cur_op));
				accepted_ops++;
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_W'({cur_op.prio, cur_op.data});
					s_tuser  <= cur_op.opcode;
					in_gap   = gap_len(in_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink: stalls at random and checks each result against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_data    = m_tdata[DW-1:0];
				got_occ     = m_tdata[DW+CW-1:DW];
				got_dropped = m_tdata[DW+CW];
				if (expected_reports.size() == 0) begin
					$error("result with no item outstanding: head_data %h", got_data);
					failures++;
				end else begin
					want = expected_reports.pop_front();
					checked++;
					if (got_data !== want.head_data) begin
						$error("head_data: expected %h, actual %h", want.head_data, got_data);
						failures++;
					end
					if (m_tuser !== want.head_valid) begin
						$error("head_valid: expected %b, actual %b", want.head_valid, m_tuser);
						failures++;
					end
					if (got_occ !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d", want.occupancy, got_occ);
						failures++;
					end
					if (got_dropped !== want.push_dropped) begin
						$error("push_dropped: expected %b, actual %b", want.push_dropped,
							got_dropped);
						failures++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				out_stall = gap_len(out_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles.", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		load_mode_t mode;
		int phase_len;
		int n_random;
		int r;
		logic [spq_pkg::OP_WIDTH-1:0] opc;

		// Empty queue first, then extremes, ties at both ends, and a full drain.
		add_op(spq_pkg::OP_POP,   32'h1234_5678, 16'h0000);
		add_op(spq_pkg::OP_QUERY, 32'hffff_ffff, 16'hffff);
		add_op(OP_SPARE,          32'h0000_0000, 16'h0000);
		add_op(spq_pkg::OP_PUSH,  32'h7fff_ffff, 16'h7fff);
		add_op(spq_pkg::OP_PUSH,  32'h8000_0000, 16'h8000);
		add_op(spq_pkg::OP_PUSH,  32'h0000_0000, 16'h0000);
		add_op(spq_pkg::OP_PUSH,  32'hffff_ffff, 16'h0000);
		add_op(spq_pkg::OP_PUSH,  32'h0000_0005, 16'h8000);
		add_op(spq_pkg::OP_PUSH,  32'h0000_0007, 16'h7fff);
		add_op(OP_SPARE,          32'hdead_beef, 16'h1234);
		add_op(spq_pkg::OP_QUERY, 32'h0000_0000, 16'h0000);
		repeat (6)
			add_op(spq_pkg::OP_POP, 32'h0000_0000, 16'h0000);
		add_op(spq_pkg::OP_POP,   32'hffff_ffff, 16'hffff);

		// Random phases that fill, drain, mix or pile up equal priorities.
		n_random = 0;
		mode     = MODE_FILL;
		while (n_random < RANDOM_OPS) begin
			phase_len = $urandom_range(15, 60);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:  opc = (r < 80) ? spq_pkg::OP_PUSH :
						(r < 92) ? spq_pkg::OP_POP : spq_pkg::OP_QUERY;
					MODE_DRAIN: opc = (r < 80) ? spq_pkg::OP_POP :
						(r < 92) ? spq_pkg::OP_PUSH : spq_pkg::OP_QUERY;
					default:    opc = (r < 45) ? spq_pkg::OP_PUSH :
						(r < 85) ? spq_pkg::OP_POP : spq_pkg::OP_QUERY;
				endcase
				if ($urandom_range(0, 29) == 0)
					opc = OP_SPARE;
				add_op(opc, pick_data(), pick_prio(mode));
				n_random++;
			end
			case ($urandom_range(0, 3))
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				2: mode = MODE_MIX;
				default: mode = MODE_TIE;
			endcase
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_ops < total_ops || expected_reports.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d items (%0d pushes, %0d pops), %0d results checked.",
			accepted_ops, n_pushes, n_pops, checked);
		$display("Queue filled %0d times, %0d pushes refused, %0d pops on empty queue.",
			n_full, n_refused, n_empty_pops);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found.", failures);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
dv/tb.sv
